// File: sv/lrp_pkg.sv
// Shared types and constants of the login response parser.
// Depends on nothing; the parser and the checker import it.
`default_nettype none

package lrp_pkg;

   // Parse phase: which field of the payload the next byte belongs to
   typedef enum logic [3:0] {
      PH_CAPS     = 4'd0,
      PH_MAXPKT   = 4'd1,
      PH_CHARSET  = 4'd2,
      PH_RESV     = 4'd3,
      PH_USER     = 4'd4,
      PH_AUTHLEN  = 4'd6,
      PH_AUTHDATA = 4'd7,
      PH_SCHEMA   = 4'd8,
      PH_PLUGIN   = 4'd9,
      PH_IGNORE   = 4'd10
   } phase_type;

   // Field tags attached to every byte
   localparam logic [3:0] TAG_CAPS     = 4'd0;
   localparam logic [3:0] TAG_MAXPKT   = 4'd1;
   localparam logic [3:0] TAG_CHARSET  = 4'd2;
   localparam logic [3:0] TAG_RESV     = 4'd3;
   localparam logic [3:0] TAG_USER     = 4'd4;
   localparam logic [3:0] TAG_USER_NUL = 4'd5;
   localparam logic [3:0] TAG_AUTHLEN  = 4'd6;
   localparam logic [3:0] TAG_AUTHDATA = 4'd7;
   localparam logic [3:0] TAG_SCHEMA   = 4'd8;
   localparam logic [3:0] TAG_PLUGIN   = 4'd9;
   localparam logic [3:0] TAG_IGNORED  = 4'd10;

   // Packet status codes
   localparam logic [2:0] STATUS_CLEAN      = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd2;
   localparam logic [2:0] STATUS_UNTERM     = 3'd3;
   localparam logic [2:0] STATUS_EMPTY_USER = 3'd4;
   localparam logic [2:0] STATUS_TOO_LONG   = 3'd5;

   // Layout constants
   localparam int         MIN_LEN        = 36;
   localparam logic [4:0] RESERVED_BYTES = 5'd23;
   localparam logic [4:0] WORD_BYTES     = 5'd4;
   localparam logic [31:0] CAP_WITH_DB   = 32'h0000_0008;
   localparam logic [31:0] CAP_PLUGIN    = 32'h0008_0000;
   localparam logic [11:0] LEN_MAX       = 12'hFFF;

   // Saturating length increment
   function automatic logic [11:0] sat_inc(input logic [11:0] v);
      return (v < LEN_MAX) ? v + 12'd1 : LEN_MAX;
   endfunction

   // Phase that follows the auth response
   function automatic phase_type after_auth(input logic [31:0] caps);
      if ((caps & CAP_WITH_DB) != 32'd0) return PH_SCHEMA;
      if ((caps & CAP_PLUGIN) != 32'd0) return PH_PLUGIN;
      return PH_IGNORE;
   endfunction

endpackage

`default_nettype wire

// File: sv/lrp_channels.sv
// Valid/ready channel interfaces of the login response parser.
// Standalone; widths follow the payload fields of each channel.
`default_nettype none

interface lrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, in_byte, is_last, input ready);
   modport sink   (input valid, in_byte, is_last, output ready);
endinterface

interface lrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [3:0]  field_tag;
   logic        packet_done;
   logic [2:0]  status;
   logic [31:0] client_caps;
   logic [31:0] max_pkt_size;
   logic [11:0] user_name_len;
   logic [7:0]  auth_resp_len;
   logic [11:0] schema_len;
   logic [11:0] plugin_len;

   modport source (output valid, out_byte, field_tag, packet_done, status, client_caps,
                   max_pkt_size, user_name_len, auth_resp_len, schema_len,
                   plugin_len, input ready);
   modport sink   (input valid, out_byte, field_tag, packet_done, status, client_caps,
                   max_pkt_size, user_name_len, auth_resp_len, schema_len,
                   plugin_len, output ready);
endinterface

`default_nettype wire

// File: sv/login_response_parser.sv
// Top level of the login response parser: byte tagger and packet checker.
// Depends on lrp_pkg and the channel interfaces in lrp_channels.sv.
//
//   channel   direction   interface        payload
//   req_ch    in          lrp_req_if       in_byte, is_last
//   rsp_ch    out         lrp_rsp_if       tagged byte, status, captured words/lengths
//
// One byte per cycle sustained while rsp_ready is high; a byte goes through the input
// register, then the result register, before rsp valid rises for it.
// The parse state is updated as a byte moves from the input register into the
// result register, so the field/status decode is a single pass of logic.
// A stalled result register holds the input register; req_ready falls only when both
// hold a byte and rsp_ready is low.
// Reset is synchronous and clears both registers' valid bits and the parse state.
`default_nettype none

module login_response_parser #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic       clock,
   input  logic       reset,
   lrp_req_if.sink    req_ch,
   lrp_rsp_if.source  rsp_ch
);
   import lrp_pkg::*;

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(MIN_LEN);

   // Input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // Result register
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic [3:0]  out_tag_ff;
   logic        out_done_ff;
   logic [2:0]  out_status_ff;
   logic [31:0] out_caps_ff;
   logic [31:0] out_maxpkt_ff;
   logic [11:0] out_user_len_ff;
   logic [7:0]  out_auth_decl_ff;
   logic [11:0] out_schema_len_ff;
   logic [11:0] out_plugin_len_ff;

   // Parse state
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   phase_type        phase_ff, phase_in;
   logic [4:0]       sub_count_ff, sub_count_in;
   logic [31:0]      caps_ff, caps_in;
   logic [31:0]      maxpkt_ff, maxpkt_in;
   logic [7:0]       auth_left_ff, auth_left_in;
   logic [11:0]      user_len_ff, user_len_in;
   logic [7:0]       auth_decl_ff, auth_decl_in;
   logic [11:0]      schema_len_ff, schema_len_in;
   logic [11:0]      plugin_len_ff, plugin_len_in;

   logic        out_free;
   logic        advance;
   logic        req_xfer;
   logic        clear_state;
   logic [4:0]  sub_inc;
   logic [7:0]  auth_dec;
   logic [31:0] byte_shift;
   logic [3:0]  tag;
   logic [2:0]  status;
   logic        schema_open;

   // Handshake: the input register moves whenever the result register is free
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign clear_state  = reset || (advance && s1_last_ff);

   // Capture the input byte
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_xfer) begin
         s1_byte_ff <= req_ch.in_byte;
         s1_last_ff <= req_ch.is_last;
      end
   end

   assign sub_inc    = sub_count_ff + 5'd1;
   assign auth_dec   = (auth_left_ff != 8'd0) ? auth_left_ff - 8'd1 : auth_left_ff;
   assign byte_shift = {24'd0, s1_byte_ff} << {sub_count_ff[1:0], 3'b000};

   // Next parse state
   always_comb begin
      byte_count_in = (byte_count_ff <= CNT_LIMIT) ? byte_count_ff + 1'b1 : byte_count_ff;
      phase_in      = phase_ff;
      sub_count_in  = sub_count_ff;
      caps_in       = caps_ff;
      maxpkt_in     = maxpkt_ff;
      auth_left_in  = auth_left_ff;
      user_len_in   = user_len_ff;
      auth_decl_in  = auth_decl_ff;
      schema_len_in = schema_len_ff;
      plugin_len_in = plugin_len_ff;
      case (phase_ff)
         PH_CAPS: begin
            caps_in = caps_ff | byte_shift;
            if (sub_inc >= WORD_BYTES) begin
               sub_count_in = 5'd0;
               phase_in     = PH_MAXPKT;
            end else begin
               sub_count_in = sub_inc;
            end
         end
         PH_MAXPKT: begin
            maxpkt_in = maxpkt_ff | byte_shift;
            if (sub_inc >= WORD_BYTES) begin
               sub_count_in = 5'd0;
               phase_in     = PH_CHARSET;
            end else begin
               sub_count_in = sub_inc;
            end
         end
         PH_CHARSET: begin
            sub_count_in = 5'd0;
            phase_in     = PH_RESV;
         end
         PH_RESV: begin
            if (sub_inc >= RESERVED_BYTES) begin
               sub_count_in = 5'd0;
               phase_in     = PH_USER;
            end else begin
               sub_count_in = sub_inc;
            end
         end
         PH_USER: begin
            if (s1_byte_ff != 8'd0) begin
               user_len_in = sat_inc(user_len_ff);
            end else begin
               phase_in = PH_AUTHLEN;
            end
         end
         PH_AUTHLEN: begin
            auth_decl_in = s1_byte_ff;
            auth_left_in = s1_byte_ff;
            phase_in     = (s1_byte_ff != 8'd0) ? PH_AUTHDATA : after_auth(caps_ff);
         end
         PH_AUTHDATA: begin
            auth_left_in = auth_dec;
            if (auth_dec == 8'd0) begin
               phase_in = after_auth(caps_ff);
            end
         end
         PH_SCHEMA: begin
            if (s1_byte_ff != 8'd0) begin
               schema_len_in = sat_inc(schema_len_ff);
            end else if (schema_len_ff != 12'd0 && (caps_ff & CAP_PLUGIN) != 32'd0) begin
               phase_in = PH_PLUGIN;
            end else begin
               phase_in = PH_IGNORE;
            end
         end
         PH_PLUGIN: begin
            if (s1_byte_ff != 8'd0) begin
               plugin_len_in = sat_inc(plugin_len_ff);
            end else begin
               phase_in = PH_IGNORE;
            end
         end
         default: begin
            phase_in = PH_IGNORE;
         end
      endcase
   end

   // Field tag of the current byte
   always_comb begin
      case (phase_ff)
         PH_CAPS:     tag = TAG_CAPS;
         PH_MAXPKT:   tag = TAG_MAXPKT;
         PH_CHARSET:  tag = TAG_CHARSET;
         PH_RESV:     tag = TAG_RESV;
         PH_USER:     tag = (s1_byte_ff != 8'd0) ? TAG_USER : TAG_USER_NUL;
         PH_AUTHLEN:  tag = TAG_AUTHLEN;
         PH_AUTHDATA: tag = TAG_AUTHDATA;
         PH_SCHEMA:   tag = TAG_SCHEMA;
         PH_PLUGIN:   tag = TAG_PLUGIN;
         default:     tag = TAG_IGNORED;
      endcase
   end

   // Packet status from the state after this byte
   assign schema_open = (phase_in == PH_SCHEMA) && (schema_len_in != 12'd0);

   always_comb begin
      if (byte_count_in > CNT_LIMIT) begin
         status = STATUS_TOO_LONG;
      end else if (byte_count_in < CNT_MIN) begin
         status = STATUS_TOO_SHORT;
      end else if (phase_in == PH_USER || phase_in == PH_AUTHLEN ||
                   (phase_in == PH_AUTHDATA && auth_left_in != 8'd0)) begin
         status = STATUS_TRUNCATED;
      end else if ((schema_open && (caps_in & CAP_PLUGIN) != 32'd0) ||
                   (phase_in == PH_PLUGIN && plugin_len_in != 12'd0)) begin
         status = STATUS_UNTERM;
      end else if (user_len_in == 12'd0) begin
         status = STATUS_EMPTY_USER;
      end else begin
         status = STATUS_CLEAN;
      end
   end

   // Advance the parse state; drop it back to reset after the last byte
   always_ff @(posedge clock) begin
      if (clear_state) begin
         byte_count_ff <= '0;
         phase_ff      <= PH_CAPS;
         sub_count_ff  <= 5'd0;
         caps_ff       <= 32'd0;
         maxpkt_ff     <= 32'd0;
         auth_left_ff  <= 8'd0;
         user_len_ff   <= 12'd0;
         auth_decl_ff  <= 8'd0;
         schema_len_ff <= 12'd0;
         plugin_len_ff <= 12'd0;
      end else if (advance) begin
         byte_count_ff <= byte_count_in;
         phase_ff      <= phase_in;
         sub_count_ff  <= sub_count_in;
         caps_ff       <= caps_in;
         maxpkt_ff     <= maxpkt_in;
         auth_left_ff  <= auth_left_in;
         user_len_ff   <= user_len_in;
         auth_decl_ff  <= auth_decl_in;
         schema_len_ff <= schema_len_in;
         plugin_len_ff <= plugin_len_in;
      end
   end

   // Load the result register; summary fields are zero except on the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_byte_ff <= s1_byte_ff;
         out_tag_ff  <= tag;
         out_done_ff <= s1_last_ff;
         if (s1_last_ff) begin
            out_status_ff     <= status;
            out_caps_ff       <= caps_in;
            out_maxpkt_ff     <= maxpkt_in;
            out_user_len_ff   <= user_len_in;
            out_auth_decl_ff  <= auth_decl_in;
            out_schema_len_ff <= schema_open ? 12'd0 : schema_len_in;
            out_plugin_len_ff <= plugin_len_in;
         end else begin
            out_status_ff     <= STATUS_CLEAN;
            out_caps_ff       <= 32'd0;
            out_maxpkt_ff     <= 32'd0;
            out_user_len_ff   <= 12'd0;
            out_auth_decl_ff  <= 8'd0;
            out_schema_len_ff <= 12'd0;
            out_plugin_len_ff <= 12'd0;
         end
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.out_byte        = out_byte_ff;
   assign rsp_ch.field_tag       = out_tag_ff;
   assign rsp_ch.packet_done     = out_done_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.client_caps     = out_caps_ff;
   assign rsp_ch.max_pkt_size    = out_maxpkt_ff;
   assign rsp_ch.user_name_len   = out_user_len_ff;
   assign rsp_ch.auth_resp_len   = out_auth_decl_ff;
   assign rsp_ch.schema_len      = out_schema_len_ff;
   assign rsp_ch.plugin_len      = out_plugin_len_ff;

endmodule

`default_nettype wire

// File: sv/lrp_checker.sv
// Port-level assertions for the login response parser, bound to the top level.
// Depends on lrp_pkg and login_response_parser.
`default_nettype none

module lrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic [3:0]  field_tag,
   input logic        packet_done,
   input logic [2:0]  status,
   input logic [31:0] client_caps,
   input logic [31:0] max_pkt_size,
   input logic [11:0] user_name_len,
   input logic [7:0]  auth_resp_len,
   input logic [11:0] schema_len,
   input logic [11:0] plugin_len
);
   import lrp_pkg::*;

   logic first_ff;
   logic first_in;

   // Track whether the next result opens a new packet
   assign first_in = (rsp_valid && rsp_ready) ? packet_done : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(field_tag) &&
      $stable(packet_done) && $stable(status) && $stable(client_caps))
      else $error("stalled result changed");

   // Summary fields stay zero inside a packet
   a_mid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !packet_done |-> status == STATUS_CLEAN && client_caps == 32'd0 &&
      max_pkt_size == 32'd0 && user_name_len == 12'd0 && auth_resp_len == 8'd0 &&
      schema_len == 12'd0 && plugin_len == 12'd0)
      else $error("summary fields set before the last byte");

   // Each packet starts in the capability field
   a_first_caps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && first_ff |-> field_tag == TAG_CAPS)
      else $error("packet did not restart at the capability field");

   // A clean packet carries a user name
   a_ok_user: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && packet_done && status == STATUS_CLEAN |-> user_name_len != 12'd0)
      else $error("clean status with empty user name");

   // Status stays within its codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= STATUS_TOO_LONG)
      else $error("status code out of range");

endmodule

bind login_response_parser lrp_checker u_lrp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .out_byte        (rsp_ch.out_byte),
   .field_tag       (rsp_ch.field_tag),
   .packet_done     (rsp_ch.packet_done),
   .status          (rsp_ch.status),
   .client_caps     (rsp_ch.client_caps),
   .max_pkt_size    (rsp_ch.max_pkt_size),
   .user_name_len   (rsp_ch.user_name_len),
   .auth_resp_len   (rsp_ch.auth_resp_len),
   .schema_len      (rsp_ch.schema_len),
   .plugin_len      (rsp_ch.plugin_len)
);

`default_nettype wire
